>>> design/bdsc_pkg.sv
package bdsc_pkg;

    // Field widths
    localparam int unsigned CntW  = 8;
    localparam int unsigned DutyW = 8;
    localparam int unsigned AdcW  = 10;
    localparam int unsigned ByteW = 8;
    localparam int unsigned ModeW = 2;

    // Register reset values
    localparam logic [CntW-1:0] DebounceReset = 8'd3;
    localparam logic [CntW-1:0] BlinkReset    = 8'd50;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_BLINK    = 1'b1
    } t_cfg_index;

    // Input kind carried on tuser
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } t_op;

    // Operating mode, one-hot
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ADC    = 3'b010,
        MODE_SERIAL = 3'b100
    } t_mode;

    // Mode codes as reported on the result word
    localparam logic [ModeW-1:0] MODE_CODE_NORMAL = 2'd0;
    localparam logic [ModeW-1:0] MODE_CODE_ADC    = 2'd1;
    localparam logic [ModeW-1:0] MODE_CODE_SERIAL = 2'd2;

    // Digit characters
    localparam logic [ByteW-1:0] CharZero = 8'h30;
    localparam logic [ByteW-1:0] CharNine = 8'h39;

    // One result word
    typedef struct packed {
        logic [DutyW-1:0] saved_value;
        logic             save_strobe;
        logic [ModeW-1:0] mode;
        logic [DutyW-1:0] duty;
        logic             led_level;
    } t_result;

    // Confirmed presses from the two debouncers
    typedef struct packed {
        logic press1;
        logic press2;
    } t_press;

    function automatic logic [ModeW-1:0] mode_code(input t_mode m);
        logic [ModeW-1:0] code;
        begin
            unique case (m)
                MODE_ADC:    code = MODE_CODE_ADC;
                MODE_SERIAL: code = MODE_CODE_SERIAL;
                default:     code = MODE_CODE_NORMAL;
            endcase
            return code;
        end
    endfunction

    // Decimal digit of a character; anything else counts as zero
    function automatic logic [3:0] char_digit(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] diff;
        begin
            diff = b - CharZero;
            if (b >= CharZero && b <= CharNine) begin
                return diff[3:0];
            end
            return 4'd0;
        end
    endfunction

endpackage

>>> design/bdsc_debounce.sv
module bdsc_debounce (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_raw,
    input  logic [bdsc_pkg::CntW-1:0]  i_thresh,
    output logic                       o_press
);

    logic                      r_stable;
    logic [bdsc_pkg::CntW-1:0] r_count;
    logic                      n_stable;
    logic [bdsc_pkg::CntW-1:0] n_count;
    logic [bdsc_pkg::CntW-1:0] inc_count;

    // Count differing ticks, flip the stable level at the threshold
    always_comb begin
        inc_count = r_count + 1'b1;
        n_stable  = r_stable;
        n_count   = '0;
        o_press   = 1'b0;
        if (i_raw != r_stable) begin
            if (inc_count >= i_thresh) begin
                n_stable = i_raw;
                o_press  = ~i_raw;
            end else begin
                n_count = inc_count;
            end
        end
    end

    // Advance only on a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_count  <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end

endmodule

>>> design/bdsc_core.sv
module bdsc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_op,
    input  logic [bdsc_pkg::AdcW-1:0]   i_adc_sample,
    input  logic [bdsc_pkg::ByteW-1:0]  i_rx_byte,
    input  bdsc_pkg::t_press            i_press,
    input  logic [bdsc_pkg::CntW-1:0]   i_blink_ticks,
    output bdsc_pkg::t_result           o_next
);

    bdsc_pkg::t_mode            r_mode, n_mode;
    logic                       r_led, n_led;
    logic [bdsc_pkg::DutyW-1:0] r_duty, n_duty;
    logic [bdsc_pkg::DutyW-1:0] r_saved, n_saved;
    logic [bdsc_pkg::CntW-1:0]  r_blink, n_blink;
    logic [bdsc_pkg::DutyW-1:0] r_accum, n_accum;
    logic                       r_pending, n_pending;
    logic                       strobe;
    logic [bdsc_pkg::CntW-1:0]  blink_inc;

    // Compute the state after one word
    always_comb begin
        n_mode    = r_mode;
        n_led     = r_led;
        n_duty    = r_duty;
        n_saved   = r_saved;
        n_blink   = r_blink;
        n_accum   = r_accum;
        n_pending = r_pending;
        strobe    = 1'b0;
        blink_inc = (r_blink == 8'hFF) ? r_blink : r_blink + 1'b1;

        if (i_op == bdsc_pkg::OP_BYTE) begin
            // accum * 10 + digit, mod 256
            n_accum   = {r_accum[4:0], 3'b000} + {r_accum[6:0], 1'b0}
                        + {4'd0, bdsc_pkg::char_digit(i_rx_byte)};
            n_pending = 1'b1;
        end else begin
            unique case (r_mode)
                bdsc_pkg::MODE_ADC: begin
                    n_duty = i_adc_sample[bdsc_pkg::AdcW-1:2];
                    if (i_press.press1) begin
                        n_led  = 1'b1;
                        n_duty = r_saved;
                        n_mode = bdsc_pkg::MODE_NORMAL;
                    end else if (i_press.press2) begin
                        n_led   = 1'b1;
                        n_saved = n_duty;
                        strobe  = 1'b1;
                        n_mode  = bdsc_pkg::MODE_NORMAL;
                    end
                end
                bdsc_pkg::MODE_SERIAL: begin
                    if (r_pending) begin
                        n_duty    = r_accum;
                        n_accum   = '0;
                        n_pending = 1'b0;
                    end
                    if (i_press.press1) begin
                        n_led  = 1'b1;
                        n_duty = r_saved;
                        n_mode = bdsc_pkg::MODE_NORMAL;
                    end else if (i_press.press2) begin
                        n_led   = 1'b1;
                        n_saved = n_duty;
                        strobe  = 1'b1;
                        n_mode  = bdsc_pkg::MODE_NORMAL;
                    end else if (blink_inc >= i_blink_ticks) begin
                        n_led   = ~r_led;
                        n_blink = '0;
                    end else begin
                        n_blink = blink_inc;
                    end
                end
                default: begin
                    if (i_press.press1) begin
                        n_led  = 1'b0;
                        n_mode = bdsc_pkg::MODE_ADC;
                    end else if (i_press.press2) begin
                        n_led   = 1'b0;
                        n_blink = '0;
                        n_mode  = bdsc_pkg::MODE_SERIAL;
                    end
                end
            endcase
        end
    end

    // Publish the updated state
    always_comb begin
        o_next.led_level   = n_led;
        o_next.duty        = n_duty;
        o_next.mode        = bdsc_pkg::mode_code(n_mode);
        o_next.save_strobe = strobe;
        o_next.saved_value = n_saved;
    end

    // Commit on each word taken from the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= bdsc_pkg::MODE_NORMAL;
            r_led     <= 1'b1;
            r_duty    <= '0;
            r_saved   <= '0;
            r_blink   <= '0;
            r_accum   <= '0;
            r_pending <= 1'b0;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_led     <= n_led;
            r_duty    <= n_duty;
            r_saved   <= n_saved;
            r_blink   <= n_blink;
            r_accum   <= n_accum;
            r_pending <= n_pending;
        end
    end

endmodule

>>> design/button_duty_setpoint_controller.sv
// Button duty setpoint controller. Each input word is a 10 ms tick (tuser 0)
// carrying raw button levels and an ADC sample, or a received serial byte
// (tuser 1). Every word yields exactly one result word with the LED level,
// duty, mode, save strobe and saved duty after that word. The block takes
// one word per clock while results are taken. A word accepted from the stream
// sits in the input register. The state update moves it into the result
// register, and the result word is valid from then on. A result word waiting
// for m_axis_tready holds the state update. While it waits, the input side
// takes at most one more word, into the input register, and then stalls until
// the result is taken. Debounce threshold and blink period are written
// through the configuration channel. Write them only while idle; the block does not enforce it.
module button_duty_setpoint_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sw1_raw, sw2_raw, adc_sample[9:0], rx_byte[7:0]
    input  logic        s_axis_tuser,   // op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // led_level, duty[7:0], mode[1:0], save_strobe,
                                        // saved_value[7:0]
);

    logic [bdsc_pkg::CntW-1:0] r_debounce;
    logic [bdsc_pkg::CntW-1:0] r_blink_ticks;

    logic                        r_in_valid;
    logic                        r_in_op;
    logic                        r_in_sw1;
    logic                        r_in_sw2;
    logic [bdsc_pkg::AdcW-1:0]   r_in_adc;
    logic [bdsc_pkg::ByteW-1:0]  r_in_byte;

    logic                r_out_valid;
    bdsc_pkg::t_result   r_out;

    logic                advance;
    logic                step;
    logic                tick;
    bdsc_pkg::t_press    press;
    bdsc_pkg::t_result   next_res;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step          = r_in_valid && advance;
    assign tick          = step && (r_in_op == bdsc_pkg::OP_TICK);

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= bdsc_pkg::DebounceReset;
            r_blink_ticks <= bdsc_pkg::BlinkReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdsc_pkg::CFG_DEBOUNCE: r_debounce    <= i_cfg_data;
                bdsc_pkg::CFG_BLINK:    r_blink_ticks <= i_cfg_data;
                default:                r_debounce    <= r_debounce;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_sw1  <= s_axis_tdata[0];
            r_in_sw2  <= s_axis_tdata[1];
            r_in_adc  <= s_axis_tdata[11:2];
            r_in_byte <= s_axis_tdata[19:12];
        end
    end

    bdsc_debounce u_deb1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (tick),
        .i_raw    (r_in_sw1),
        .i_thresh (r_debounce),
        .o_press  (press.press1)
    );

    bdsc_debounce u_deb2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (tick),
        .i_raw    (r_in_sw2),
        .i_thresh (r_debounce),
        .o_press  (press.press2)
    );

    bdsc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (step),
        .i_op          (r_in_op),
        .i_adc_sample  (r_in_adc),
        .i_rx_byte     (r_in_byte),
        .i_press       (press),
        .i_blink_ticks (r_blink_ticks),
        .o_next        (next_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= next_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    // A save always leaves edit mode with the saved value equal to the duty
    a_save_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.save_strobe) |->
        (r_out.saved_value == r_out.duty && r_out.mode == bdsc_pkg::MODE_CODE_NORMAL))
        else $error("save strobe with inconsistent duty or mode");

    // LED is lit in normal mode and dark in ADC edit mode
    a_led_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        ((r_out.mode == bdsc_pkg::MODE_CODE_NORMAL && r_out.led_level) ||
         (r_out.mode == bdsc_pkg::MODE_CODE_ADC && !r_out.led_level) ||
         (r_out.mode == bdsc_pkg::MODE_CODE_SERIAL)))
        else $error("LED level disagrees with mode");

    // A stalled pipeline must not commit a word
    a_no_step_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !step)
        else $error("state updated while result stalled");

    // A byte word never changes duty or mode
    a_byte_keeps_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_op == bdsc_pkg::OP_BYTE && r_out_valid) |->
        (next_res.duty == r_out.duty && next_res.mode == r_out.mode))
        else $error("serial byte changed duty or mode");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bdsc_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned DrainCycles = 6;
    localparam int unsigned MaxPrinted = 20;

    // Clock, reset and block inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata = 24'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;

    // Predicted controller state and register copies
    t_mode       ctl_mode;
    logic        sw1_level, sw2_level;
    logic [7:0]  sw1_run, sw2_run;
    logic        led_q;
    logic [7:0]  duty_q, saved_q;
    logic        blinking;
    logic [7:0]  blink_run;
    logic [7:0]  rx_value;
    logic        rx_seen;
    logic [7:0]  debounce_limit;
    logic [7:0]  blink_period;

    t_result     expected_status[$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned in_gap_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    button_duty_setpoint_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MaxPrinted) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // Return to the reset state of the controller
    task automatic clear_controller();
        ctl_mode = MODE_NORMAL;
        sw1_level = 1'b1; sw1_run = 8'd0;
        sw2_level = 1'b1; sw2_run = 8'd0;
        led_q = 1'b1;
        duty_q = 8'd0;
        saved_q = 8'd0;
        blinking = 1'b0;
        blink_run = 8'd0;
        rx_value = 8'd0;
        rx_seen = 1'b0;
        debounce_limit = DebounceReset;
        blink_period = BlinkReset;
    endtask

    // Debounce one button; flag a press on a confirmed falling level
    task automatic settle_button(input logic raw, inout logic level, inout logic [7:0] run,
                                 output logic pressed);
        pressed = 1'b0;
        if (raw == level) begin
            run = 8'd0;
        end else begin
            run = run + 8'd1;
            if (run >= debounce_limit) begin
                level = raw;
                run = 8'd0;
                pressed = ~raw;
            end
        end
    endtask

    // Apply one accepted word and queue the status it must produce
    task automatic advance_controller(input t_op op, input logic sw1, input logic sw2,
                                      input logic [9:0] adc, input logic [7:0] rx);
        logic      p1, p2, strobe;
        logic [7:0] digit;
        t_result   status;
        strobe = 1'b0;
        if (op == OP_BYTE) begin
            digit = (rx >= CharZero && rx <= CharNine) ? rx - CharZero : 8'd0;
            rx_value = rx_value * 8'd10 + digit;
            rx_seen = 1'b1;
        end else begin
            settle_button(sw1, sw1_level, sw1_run, p1);
            settle_button(sw2, sw2_level, sw2_run, p2);
            case (ctl_mode)
                MODE_ADC: begin
                    duty_q = adc[9:2];
                    if (p1) begin
                        led_q = 1'b1; duty_q = saved_q; ctl_mode = MODE_NORMAL;
                    end else if (p2) begin
                        led_q = 1'b1; saved_q = duty_q; strobe = 1'b1;
                        ctl_mode = MODE_NORMAL;
                    end
                end
                MODE_SERIAL: begin
                    // consume the bytes gathered since the last tick
                    if (rx_seen) begin
                        duty_q = rx_value;
                        rx_value = 8'd0;
                        rx_seen = 1'b0;
                    end
                    if (p1) begin
                        led_q = 1'b1; duty_q = saved_q; blinking = 1'b0;
                        ctl_mode = MODE_NORMAL;
                    end else if (p2) begin
                        led_q = 1'b1; saved_q = duty_q; strobe = 1'b1; blinking = 1'b0;
                        ctl_mode = MODE_NORMAL;
                    end else begin
                        if (blink_run != 8'hFF) blink_run = blink_run + 8'd1;
                        if (blink_run >= blink_period) begin
                            led_q = ~led_q;
                            blink_run = 8'd0;
                            blinking = 1'b1;
                        end
                    end
                end
                default: begin
                    if (p1) begin
                        led_q = 1'b0; ctl_mode = MODE_ADC;
                    end else if (p2) begin
                        led_q = 1'b0; blinking = 1'b1; blink_run = 8'd0;
                        ctl_mode = MODE_SERIAL;
                    end
                end
            endcase
        end
        status.led_level = led_q;
        status.duty = duty_q;
        case (ctl_mode)
            MODE_ADC:    status.mode = MODE_CODE_ADC;
            MODE_SERIAL: status.mode = MODE_CODE_SERIAL;
            default:     status.mode = MODE_CODE_NORMAL;
        endcase
        status.save_strobe = strobe;
        status.saved_value = saved_q;
        expected_status.push_back(status);
    endtask

    // Send one word, with an optional idle burst ahead of it
    task automatic send_word(input t_op op, input logic sw1, input logic sw2,
                             input logic [9:0] adc, input logic [7:0] rx);
        @(negedge i_clk);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'b0000, rx, adc, sw2, sw1};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_controller(op, sw1, sw2, adc, rx);
        words_sent++;
    endtask

    task automatic send_tick(input logic sw1, input logic sw2, input logic [9:0] adc);
        send_word(OP_TICK, sw1, sw2, adc, 8'($urandom_range(0, 255)));
    endtask

    // Fields other than the byte are don't-care here, so randomize them
    task automatic send_byte(input logic [7:0] rx);
        send_word(OP_BYTE, 1'($urandom), 1'($urandom), 10'($urandom_range(0, 1023)), rx);
    endtask

    task automatic hold_buttons(input logic sw1, input logic sw2, input int unsigned ticks);
        repeat (ticks) send_tick(sw1, sw2, 10'($urandom_range(0, 1023)));
    endtask

    // Drop valid and wait until every status word is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [7:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE: debounce_limit = value;
            default:      blink_period = value;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly complete press/release sequences, some glitches, bytes and noise
    task automatic run_random(input int unsigned count);
        int unsigned stop_at, pick, span;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            span = (debounce_limit == 0) ? 1 : debounce_limit;
            if (!quiet) begin
                in_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
                out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                hold_buttons(1'b0, 1'b1, span + $urandom_range(0, 1));
                hold_buttons(1'b1, 1'b1, span + $urandom_range(0, 2));
            end else if (pick < 50) begin
                hold_buttons(1'b1, 1'b0, span + $urandom_range(0, 1));
                hold_buttons(1'b1, 1'b1, span + $urandom_range(0, 2));
            end else if (pick < 55) begin
                hold_buttons(1'b0, 1'b0, span + $urandom_range(0, 1));
                hold_buttons(1'b1, 1'b1, span + $urandom_range(0, 2));
            end else if (pick < 65) begin
                hold_buttons(1'($urandom), 1'($urandom), $urandom_range(1, span));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) != 0) send_byte(CharZero + 8'($urandom_range(0, 9)));
                    else send_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_tick(1'($urandom), 1'($urandom), 10'($urandom_range(0, 1023)));
                end
            end
        end
    endtask

    // Digit wrap, non-digits, every mode change and button priority
    task automatic test_directed_defaults();
        in_gap_pct = 20;
        out_stall_pct = 20;
        send_byte(CharNine);
        send_byte(CharNine);
        send_byte(CharNine);
        send_byte(8'hFF);
        send_byte(CharZero - 8'd1);
        send_byte(CharNine + 8'd1);
        send_byte(8'h00);
        send_byte(CharZero);
        repeat (3) send_tick(1'b1, 1'b0, 10'h3FF);
        send_tick(1'b1, 1'b1, 10'h3FF);
        repeat (3) send_tick(1'b0, 1'b1, 10'h000);
        repeat (3) send_tick(1'b1, 1'b1, 10'h3FF);
        repeat (3) send_tick(1'b0, 1'b0, 10'h3FF);
        repeat (3) send_tick(1'b1, 1'b1, 10'h000);
        repeat (3) send_tick(1'b1, 1'b0, 10'h3FF);
    endtask

    task automatic test_random_defaults();
        run_random(300);
    endtask

    // Zero in either register acts on the first qualifying tick
    task automatic test_zero_registers();
        wait_drained();
        write_register(CFG_DEBOUNCE, 8'd0);
        write_register(CFG_BLINK, 8'd0);
        run_random(250);
    endtask

    task automatic test_fast_settings();
        wait_drained();
        write_register(CFG_DEBOUNCE, 8'd1);
        write_register(CFG_BLINK, 8'($urandom_range(1, 5)));
        run_random(350);
    endtask

    // Largest settings: one long press into serial mode, then a long release
    task automatic test_long_settings();
        wait_drained();
        write_register(CFG_DEBOUNCE, 8'd255);
        write_register(CFG_BLINK, 8'd255);
        hold_buttons(1'b1, 1'b0, 256);
        for (int i = 0; i < 300; i++) begin
            if (i % 25 == 0) send_byte(CharZero + 8'($urandom_range(0, 9)));
            else send_tick(1'b1, 1'b1, 10'($urandom_range(0, 1023)));
        end
    endtask

    // Final stretch at full rate on both sides
    task automatic test_mixed_settings();
        quiet = 1'b1;
        in_gap_pct = 0;
        out_stall_pct = 0;
        repeat (3) begin
            wait_drained();
            write_register(CFG_DEBOUNCE, 8'($urandom_range(1, 6)));
            write_register(CFG_BLINK, 8'($urandom_range(1, 20)));
            run_random(100);
        end
    endtask

    // Result side backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each status word with the oldest prediction
    always @(posedge i_clk) begin : check_status
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[19:0];
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                want = expected_status.pop_front();
                if (got.led_level !== want.led_level)
                    report_mismatch($sformatf("led_level %b, want %b",
                                              got.led_level, want.led_level));
                if (got.duty !== want.duty)
                    report_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
                if (got.mode !== want.mode)
                    report_mismatch($sformatf("mode %0d, want %0d", got.mode, want.mode));
                if (got.save_strobe !== want.save_strobe)
                    report_mismatch($sformatf("save_strobe %b, want %b",
                                              got.save_strobe, want.save_strobe));
                if (got.saved_value !== want.saved_value)
                    report_mismatch($sformatf("saved_value %0d, want %0d",
                                              got.saved_value, want.saved_value));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        clear_controller();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_random_defaults();
        test_zero_registers();
        test_fast_settings();
        test_long_settings();
        test_mixed_settings();
        wait_drained();
        if (expected_status.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", expected_status.size()));
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bdsc_pkg.sv
design/bdsc_debounce.sv
design/bdsc_core.sv
design/button_duty_setpoint_controller.sv
bench/tb_top.sv
